// ----- hw/rtl/eib_pkg.sv -----
package eib_pkg;

	localparam int CODE_W = 15;

	// "JFK" packed base 26 with A = 0
	localparam logic [CODE_W-1:0] RESET_START = 15'd6224;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_INIT   = 7'b0000010,
		S_SCAN   = 7'b0000100,
		S_DECIDE = 7'b0001000,
		S_POPLD  = 7'b0010000,
		S_OUTRD  = 7'b0100000,
		S_OUTLD  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic load;
		logic init;
		logic scan_clr;
		logic scan_run;
		logic push;
		logic pop;
		logic pop_load;
		logic out_rd;
		logic out_ld;
		logic done;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic found;
		logic stack_room;
		logic depth_one;
		logic route_last;
		logic out_busy;
	} sts_t;

endpackage

// ----- hw/rtl/eib_ctrl.sv -----
module eib_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          last_ticket,
	output logic          in_ready,
	input  eib_pkg::sts_t sts,
	output eib_pkg::cmd_t cmd
);

	eib_pkg::state_t state_q, state_nxt;
	logic            accept;

	assign in_ready = (state_q == eib_pkg::S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			eib_pkg::S_IDLE: begin
				cmd.load = accept;
				if (accept && last_ticket) begin
					state_nxt = eib_pkg::S_INIT;
				end
			end
			eib_pkg::S_INIT: begin
				cmd.init     = 1'b1;
				cmd.scan_clr = 1'b1;
				state_nxt    = eib_pkg::S_SCAN;
			end
			eib_pkg::S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					state_nxt = eib_pkg::S_DECIDE;
				end
			end
			eib_pkg::S_DECIDE: begin
				if (sts.found && sts.stack_room) begin
					cmd.push     = 1'b1;
					cmd.scan_clr = 1'b1;
					state_nxt    = eib_pkg::S_SCAN;
				end else begin
					// dead end: pop the top onto the route
					cmd.pop = 1'b1;
					if (sts.depth_one) begin
						state_nxt = eib_pkg::S_OUTRD;
					end else begin
						state_nxt = eib_pkg::S_POPLD;
					end
				end
			end
			eib_pkg::S_POPLD: begin
				cmd.pop_load = 1'b1;
				cmd.scan_clr = 1'b1;
				state_nxt    = eib_pkg::S_SCAN;
			end
			eib_pkg::S_OUTRD: begin
				if (!sts.out_busy) begin
					cmd.out_rd = 1'b1;
					state_nxt  = eib_pkg::S_OUTLD;
				end
			end
			eib_pkg::S_OUTLD: begin
				cmd.out_ld = 1'b1;
				if (sts.route_last) begin
					cmd.done  = 1'b1;
					state_nxt = eib_pkg::S_IDLE;
				end else begin
					state_nxt = eib_pkg::S_OUTRD;
				end
			end
			default: begin
				state_nxt = eib_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eib_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ----- hw/rtl/eib_datapath.sv -----
module eib_datapath #(
	parameter int TICKET_SLOTS = 63
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [eib_pkg::CODE_W-1:0] cfg_wdata,
	input  logic [eib_pkg::CODE_W-1:0] from_airport,
	input  logic [eib_pkg::CODE_W-1:0] to_airport,
	input  eib_pkg::cmd_t              cmd,
	output eib_pkg::sts_t              sts,
	output logic [eib_pkg::CODE_W-1:0] airport,
	output logic                       last_stop,
	output logic                       out_valid,
	input  logic                       out_ready
);

	localparam int CW     = eib_pkg::CODE_W;
	localparam int IDX_W  = (TICKET_SLOTS > 1) ? $clog2(TICKET_SLOTS) : 1;
	localparam int CNT_W  = $clog2(TICKET_SLOTS + 1);
	localparam int SIDX_W = $clog2(TICKET_SLOTS + 1);
	localparam int DEP_W  = $clog2(TICKET_SLOTS + 2);
	localparam logic [CNT_W-1:0] MAX_CNT     = CNT_W'(TICKET_SLOTS);
	localparam logic [DEP_W-1:0] ROUTE_DEPTH = DEP_W'(TICKET_SLOTS + 1);

	// ticket table: source in the upper half, destination in the lower
	logic [2*CW-1:0]         ticket_mem [TICKET_SLOTS];
	logic [CW-1:0]           stack_mem  [TICKET_SLOTS+1];
	logic [CW-1:0]           route_mem  [TICKET_SLOTS+1];

	logic [TICKET_SLOTS-1:0] used_q;
	logic [CNT_W-1:0]        count_q;
	logic [CW-1:0]           start_q;
	logic [CW-1:0]           top_q;
	logic [DEP_W-1:0]        depth_q;
	logic [DEP_W-1:0]        rlen_q;
	logic [SIDX_W-1:0]       ptr_q;

	logic [CNT_W-1:0]        scan_idx_q;
	logic                    rd_vld_s1;
	logic [IDX_W-1:0]        rd_idx_s1;
	logic [2*CW-1:0]         tk_rd_s1;
	logic                    found_q;
	logic [IDX_W-1:0]        best_idx_q;
	logic [CW-1:0]           best_dest_q;
	logic [CW-1:0]           stack_rd_q;
	logic [CW-1:0]           route_rd_q;
	logic                    out_valid_q;

	logic                    issue;
	logic                    hit;
	logic                    take_load;
	logic [CW-1:0]           rd_src;
	logic [CW-1:0]           rd_dst;

	assign take_load = cmd.load && (count_q < MAX_CNT);
	assign issue     = cmd.scan_run && (scan_idx_q < count_q);
	assign rd_src    = tk_rd_s1[2*CW-1:CW];
	assign rd_dst    = tk_rd_s1[CW-1:0];
	assign hit       = rd_vld_s1 && !used_q[rd_idx_s1] && (rd_src == top_q);

	assign sts.scan_done  = (scan_idx_q >= count_q) && !rd_vld_s1;
	assign sts.found      = found_q;
	assign sts.stack_room = (depth_q < ROUTE_DEPTH);
	assign sts.depth_one  = (depth_q == DEP_W'(1));
	assign sts.route_last = (ptr_q == '0);
	assign sts.out_busy   = out_valid_q;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (take_load) begin
			ticket_mem[count_q[IDX_W-1:0]] <= {from_airport, to_airport};
		end
		if (issue) begin
			tk_rd_s1 <= ticket_mem[scan_idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			stack_mem[0] <= start_q;
		end else if (cmd.push) begin
			stack_mem[depth_q[SIDX_W-1:0]] <= best_dest_q;
		end
		if (cmd.pop && (depth_q > DEP_W'(1))) begin
			stack_rd_q <= stack_mem[SIDX_W'(depth_q - DEP_W'(2))];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop && (rlen_q < ROUTE_DEPTH)) begin
			route_mem[rlen_q[SIDX_W-1:0]] <= top_q;
		end
		if (cmd.out_rd) begin
			route_rd_q <= route_mem[ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx_q[IDX_W-1:0];
		if (hit && (!found_q || (rd_dst < best_dest_q))) begin
			best_idx_q  <= rd_idx_s1;
			best_dest_q <= rd_dst;
		end
		if (cmd.init) begin
			top_q <= start_q;
		end else if (cmd.push) begin
			top_q <= best_dest_q;
		end else if (cmd.pop_load) begin
			top_q <= stack_rd_q;
		end
		if (cmd.out_ld) begin
			airport   <= route_rd_q;
			last_stop <= (ptr_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= eib_pkg::RESET_START;
			used_q      <= '0;
			count_q     <= '0;
			depth_q     <= '0;
			rlen_q      <= '0;
			ptr_q       <= '0;
			scan_idx_q  <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				start_q <= cfg_wdata;
			end

			if (cmd.load) begin
				if (take_load) begin
					// a new load clears every used mark, later tickets only their own
					if (count_q == '0) begin
						used_q <= '0;
					end else begin
						used_q[count_q[IDX_W-1:0]] <= 1'b0;
					end
					count_q <= count_q + CNT_W'(1);
				end
			end else if (cmd.push) begin
				used_q[best_idx_q] <= 1'b1;
			end
			if (cmd.done) begin
				count_q <= '0;
			end

			rd_vld_s1 <= issue;
			if (cmd.scan_clr) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
			end else begin
				if (issue) begin
					scan_idx_q <= scan_idx_q + CNT_W'(1);
				end
				if (hit) begin
					found_q <= 1'b1;
				end
			end

			if (cmd.init) begin
				depth_q <= DEP_W'(1);
				rlen_q  <= '0;
			end else if (cmd.push) begin
				depth_q <= depth_q + DEP_W'(1);
			end else if (cmd.pop) begin
				depth_q <= depth_q - DEP_W'(1);
				if (rlen_q < ROUTE_DEPTH) begin
					rlen_q <= rlen_q + DEP_W'(1);
					ptr_q  <= rlen_q[SIDX_W-1:0];
				end
			end else if (cmd.out_ld && (ptr_q != '0)) begin
				ptr_q <= ptr_q - SIDX_W'(1);
			end

			// hold the result until the transfer, then free the slot
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= ROUTE_DEPTH)
		else $error("walk stack depth beyond its store");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> !out_valid_q)
		else $error("pending result overwritten");

	a_push_legal: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (found_q && depth_q < ROUTE_DEPTH))
		else $error("push without an unused ticket or stack room");

	a_route_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_rd |-> (rlen_q != '0))
		else $error("route read with no stop stored");

	a_used_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> used_q[$past(best_idx_q)])
		else $error("ticket not marked used after push");

endmodule

// ----- hw/rtl/eulerian_itinerary_builder.sv -----
// Eulerian itinerary builder. Tickets arrive one per transfer on the input
// channel and are taken while the block is idle; tickets beyond TICKET_SLOTS
// are dropped. The ticket marked last_ticket starts a Hierholzer walk from
// start_airport (reset "JFK"), always taking the smallest unused destination,
// and the route is then sent on the output channel in travel order with
// last_stop set on the final airport. The walk is a loop over push and pop
// steps; each push and every pop but the last is followed by a scan of the
// ticket table through its single read port, one entry a cycle. With n stored
// tickets there are 2n + 1 steps. No new ticket is taken until the final
// airport of the route sits in the output register. start_airport is written
// through cfg_we / cfg_wdata while the block is idle; the user is bound to
// this, and the block itself does not enforce it.
module eulerian_itinerary_builder #(
	parameter int TICKET_SLOTS = 63
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [eib_pkg::CODE_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [eib_pkg::CODE_W-1:0] from_airport,
	input  logic [eib_pkg::CODE_W-1:0] to_airport,
	input  logic                       last_ticket,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [eib_pkg::CODE_W-1:0] airport,
	output logic                       last_stop
);

	eib_pkg::cmd_t cmd;
	eib_pkg::sts_t sts;

	eib_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.last_ticket (last_ticket),
		.in_ready    (in_ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	eib_datapath #(
		.TICKET_SLOTS (TICKET_SLOTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.from_airport (from_airport),
		.to_airport   (to_airport),
		.cmd          (cmd),
		.sts          (sts),
		.airport      (airport),
		.last_stop    (last_stop),
		.out_valid    (out_valid),
		.out_ready    (out_ready)
	);

endmodule
